/* rtl/rttt_pkg.sv */
package rttt_pkg;

  localparam int SLOTS_DEF    = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int ISQ_W        = 48;
  localparam int ISQ_STEPS    = ISQ_W / 2;
  localparam int DIV_N_W      = 26;
  localparam int DIV_D_W      = 16;

  localparam logic [1:0] OP_FRAME  = 2'd0;
  localparam logic [1:0] OP_DETECT = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  localparam logic [1:0] REG_GAIN   = 2'd0;
  localparam logic [1:0] REG_EXPIRY = 2'd1;
  localparam logic [1:0] REG_NONE   = 2'd3;

  localparam logic [16:0] GAIN_RESET   = 17'd6554;
  localparam logic [16:0] GAIN_ONE     = 17'd65536;
  localparam logic [7:0]  EXPIRY_RESET = 8'd10;
  localparam logic [15:0] DT_RESET     = 16'd50;
  localparam logic [7:0]  LOST_RESET   = 8'd100;
  localparam logic [7:0]  LOST_MAX     = 8'd255;

  // Quarter turn in 1/256 centidegree.
  localparam logic signed [23:0] QUARTER_TURN = 24'sd2304000;

  typedef struct packed {
    logic               valid;
    logic [7:0]         ident;
    logic [7:0]         lost;
    logic signed [23:0] xpos;
    logic signed [23:0] ypos;
    logic [15:0]        rng;
  } slot_t;

  localparam slot_t SLOT_RESET = '{valid: 1'b0, ident: 8'd0, lost: LOST_RESET,
                                   xpos: 24'sd0, ypos: 24'sd0, rng: 16'd0};

  typedef struct packed {
    logic clear;
    logic tick;
    logic shift;
  } cell_ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN, ST_PICK, ST_MUL0, ST_MUL1, ST_MUL2, ST_MUL3, ST_MUL4,
    ST_MUL5, ST_MUL6, ST_ROOT, ST_SPEED, ST_DIV, ST_ANGLE, ST_DONE
  } state_t;

  // Arctangent of 2^-i in 1/256 centidegree.
  function automatic logic [20:0] atan_val(input logic [3:0] i);
    logic [20:0] a;
    case (i)
      4'd0:    a = 21'd1152000;
      4'd1:    a = 21'd680065;
      4'd2:    a = 21'd359328;
      4'd3:    a = 21'd182400;
      4'd4:    a = 21'd91554;
      4'd5:    a = 21'd45822;
      4'd6:    a = 21'd22916;
      4'd7:    a = 21'd11459;
      4'd8:    a = 21'd5730;
      4'd9:    a = 21'd2865;
      4'd10:   a = 21'd1432;
      4'd11:   a = 21'd716;
      4'd12:   a = 21'd358;
      4'd13:   a = 21'd179;
      4'd14:   a = 21'd90;
      default: a = 21'd45;
    endcase
    return a;
  endfunction

endpackage

/* rtl/rttt_if.sv */
interface rttt_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic [7:0]         target_id;
  logic signed [15:0] x_mm;
  logic signed [15:0] y_mm;
  logic [15:0]        frame_interval_ms;

  modport source (output valid, op, target_id, x_mm, y_mm, frame_interval_ms,
                  input ready);
  modport sink (input valid, op, target_id, x_mm, y_mm, frame_interval_ms,
                output ready);
endinterface

interface rttt_out_if;
  logic               valid;
  logic               ready;
  logic               slot_found;
  logic [3:0]         slot_index;
  logic [7:0]         track_id;
  logic signed [23:0] smooth_x;
  logic signed [23:0] smooth_y;
  logic [15:0]        range_mm;
  logic signed [15:0] bearing_centideg;
  logic signed [23:0] radial_speed;
  logic [4:0]         active_count;

  modport source (output valid, slot_found, slot_index, track_id, smooth_x, smooth_y,
                  range_mm, bearing_centideg, radial_speed, active_count,
                  input ready);
  modport sink (input valid, slot_found, slot_index, track_id, smooth_x, smooth_y,
                range_mm, bearing_centideg, radial_speed, active_count,
                output ready);
endinterface

/* rtl/rttt_cell.sv */
module rttt_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  rttt_pkg::cell_ctl_t ctl,
  input  logic              wr_en,
  input  rttt_pkg::slot_t   wr_data,
  input  rttt_pkg::slot_t   prev,
  output rttt_pkg::slot_t   q
);

  rttt_pkg::slot_t slot_r, slot_nxt;

  always_comb begin
    slot_nxt = slot_r;
    if (ctl.clear) begin
      slot_nxt = rttt_pkg::SLOT_RESET;
    end else if (wr_en) begin
      slot_nxt = wr_data;
    end else if (ctl.shift) begin
      slot_nxt = prev;
    end else if (ctl.tick && slot_r.lost != rttt_pkg::LOST_MAX) begin
      slot_nxt.lost = slot_r.lost + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= rttt_pkg::SLOT_RESET;
    end else begin
      slot_r <= slot_nxt;
    end
  end

  assign q = slot_r;

endmodule

/* rtl/rttt_isqrt.sv */
module rttt_isqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [rttt_pkg::ISQ_W-1:0]  operand,
  output logic                        busy,
  output logic [rttt_pkg::ISQ_W/2-1:0] root
);

  localparam int W = rttt_pkg::ISQ_W;

  logic [W-1:0] n_r, res_r, bit_r;
  logic [4:0]   cnt_r;
  logic         busy_r;
  logic [W-1:0] trial;

  assign trial = res_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 5'd1;
      if (cnt_r == 5'(rttt_pkg::ISQ_STEPS - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r   <= operand;
      res_r <= '0;
      bit_r <= W'(1) << (W - 2);
    end else if (busy_r) begin
      if (n_r >= trial) begin
        n_r   <= n_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign busy = busy_r;
  assign root = res_r[W/2-1:0];

endmodule

/* rtl/rttt_cordic.sv */
module rttt_cordic (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [23:0] x,
  input  logic signed [23:0] y,
  output logic               busy,
  output logic signed [15:0] angle
);

  logic signed [33:0] u_r, v_r, u0, v0, du, dv;
  logic signed [23:0] z_r, z0, atan_s;
  logic [3:0]         i_r;
  logic               busy_r;
  logic signed [24:0] z_rnd;
  logic signed [16:0] z_cd;

  // The half plane with negative y is first turned by a quarter so that u is not negative.
  always_comb begin
    u0 = 34'(y) <<< 6;
    v0 = 34'(x) <<< 6;
    z0 = '0;
    if (u0 < 0) begin
      if (v0 >= 0) begin
        u0 = 34'(x) <<< 6;
        v0 = -(34'(y) <<< 6);
        z0 = rttt_pkg::QUARTER_TURN;
      end else begin
        u0 = -(34'(x) <<< 6);
        v0 = 34'(y) <<< 6;
        z0 = -rttt_pkg::QUARTER_TURN;
      end
    end
  end

  assign du     = v_r >>> i_r;
  assign dv     = u_r >>> i_r;
  assign atan_s = 24'(rttt_pkg::atan_val(i_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      i_r    <= '0;
    end else if (start) begin
      busy_r <= !(x == 24'sd0 && y == 24'sd0);
      i_r    <= '0;
    end else if (busy_r) begin
      i_r <= i_r + 4'd1;
      if (i_r == 4'(rttt_pkg::CORDIC_STEPS - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      u_r <= u0;
      v_r <= v0;
      z_r <= (x == 24'sd0 && y == 24'sd0) ? 24'sd0 : z0;
    end else if (busy_r) begin
      if (v_r >= 0) begin
        u_r <= u_r + du;
        v_r <= v_r - dv;
        z_r <= z_r + atan_s;
      end else begin
        u_r <= u_r - du;
        v_r <= v_r + dv;
        z_r <= z_r - atan_s;
      end
    end
  end

  assign z_rnd = 25'(z_r) + 25'sd128;
  assign z_cd  = 17'(z_rnd >>> 8);

  always_comb begin
    if (z_cd > 17'sd18000) begin
      angle = 16'sd18000;
    end else if (z_cd < -17'sd18000) begin
      angle = -16'sd18000;
    end else begin
      angle = 16'(z_cd);
    end
  end

  assign busy = busy_r;

endmodule

/* rtl/rttt_divider.sv */
module rttt_divider (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [rttt_pkg::DIV_N_W-1:0]  dividend,
  input  logic [rttt_pkg::DIV_D_W-1:0]  divisor,
  output logic                          busy,
  output logic [rttt_pkg::DIV_N_W-1:0]  quotient
);

  localparam int NW = rttt_pkg::DIV_N_W;
  localparam int DW = rttt_pkg::DIV_D_W;

  logic [DW-1:0] rem_r, dvs_r;
  logic [NW-1:0] quo_r;
  logic [4:0]    cnt_r;
  logic          busy_r;
  logic [DW:0]   shifted;
  logic          take;

  assign shifted = {rem_r, quo_r[NW-1]};
  assign take    = shifted >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 5'd1;
      if (cnt_r == 5'(NW - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= take ? DW'(shifted - {1'b0, dvs_r}) : shifted[DW-1:0];
      quo_r <= {quo_r[NW-2:0], take};
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

/* rtl/radar_target_track_table_core.sv */
// Channel  Direction  Payload
// in_ch    sink       op, target_id, x_mm, y_mm, frame_interval_ms
// out_ch   source     slot_found .. active_count, one result per detection
// cfg_*    write      cfg_index 0 smoothing_gain, 1 expiry_limit
//
// A frame start, clear or unused op yields no result and leaves the block idle.
// For a detection the ring first rotates once past the search head; then, when
// a slot is found, one shared multiplier runs the smoothing and squares, then the
// 24-step root and, when the slot held an earlier range, the 26-step divider run
// in turn, the CORDIC working alongside. When no slot is found the result follows
// the rotation directly. The block is ready for the next request once the result
// is in the output register. Reset is synchronous and restores the table.
// A result waits in the output register while the next request is taken;
// a detection finding that register still full waits until it drains.
module radar_target_track_table_core #(
  parameter int SLOTS = rttt_pkg::SLOTS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  rttt_in_if.sink       in_ch,
  rttt_out_if.source    out_ch,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [16:0]   cfg_wdata
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);

  rttt_pkg::state_t state_r, state_nxt;

  logic [16:0] gain_r;
  logic [7:0]  expiry_r;
  logic [15:0] dt_r;

  rttt_pkg::slot_t   cell_q [SLOTS];
  rttt_pkg::slot_t   head, sel, wr_slot;
  rttt_pkg::cell_ctl_t ctl;
  logic [SLOTS-1:0]  wr_en;

  logic [IDX_W-1:0] scan_r, match_idx_r, free_idx_r, sel_idx;
  logic             match_hit_r, free_hit_r, hit;
  rttt_pkg::slot_t  match_s_r, free_s_r;
  logic [CNT_W-1:0] tot_r, cnt_fin;

  logic [7:0]         id_r;
  logic signed [15:0] sx_r, sy_r;

  logic [16:0]        g, ig;
  logic signed [24:0] mul_a, mul_b;
  logic signed [49:0] prod_r, t_r;
  logic signed [23:0] x_r, y_r;
  logic [15:0]        r_r;
  logic signed [23:0] spd_r;
  logic               neg_r;

  logic        isq_start, cor_start, div_start, shift_en, load_out, accept;
  logic        isq_busy, cor_busy, div_busy;
  logic [23:0] root;
  logic [24:0] root_rnd;
  logic signed [15:0] angle;
  logic [25:0] quo;
  logic signed [16:0] diff;
  logic signed [27:0] num;
  logic [25:0] mag_in;

  logic               out_valid_r, out_found_r;
  logic [3:0]         out_idx_r;
  logic [7:0]         out_id_r;
  logic signed [23:0] out_x_r, out_y_r, out_spd_r;
  logic [15:0]        out_rng_r;
  logic signed [15:0] out_brg_r;
  logic [4:0]         out_act_r;

  function automatic logic signed [23:0] blend(input logic signed [49:0] a,
                                               input logic signed [49:0] b);
    logic signed [51:0] v;
    logic signed [35:0] s;
    v = (52'(a) <<< 8) + 52'(b) + 52'sd32768;
    s = 36'(v >>> 16);
    if (s > 36'sd8388607) begin
      return 24'sd8388607;
    end else if (s < -36'sd8388608) begin
      return -24'sd8388608;
    end
    return 24'(s);
  endfunction

  // Slot ring: cell i takes from cell i+1, cell 0 is the search head.
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    rttt_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .wr_en   (wr_en[i]),
      .wr_data (wr_slot),
      .prev    (cell_q[(i + 1) % SLOTS]),
      .q       (cell_q[i])
    );
    assign wr_en[i] = load_out && hit && (sel_idx == IDX_W'(i));
  end

  assign head    = cell_q[0];
  assign hit     = match_hit_r || free_hit_r;
  assign sel     = match_hit_r ? match_s_r : free_s_r;
  assign sel_idx = match_hit_r ? match_idx_r : free_idx_r;
  assign g       = (gain_r > rttt_pkg::GAIN_ONE) ? rttt_pkg::GAIN_ONE : gain_r;
  assign ig      = rttt_pkg::GAIN_ONE - g;
  assign accept  = in_ch.valid && in_ch.ready;

  assign wr_slot = '{valid: 1'b1, ident: id_r, lost: 8'd0, xpos: x_r, ypos: y_r,
                     rng: r_r};

  // The updated slot ends up active, so its old contribution is swapped out.
  assign cnt_fin = tot_r - CNT_W'(hit && sel.valid && sel.lost == 8'd0)
                   + CNT_W'(hit);

  rttt_isqrt u_isqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (isq_start),
    .operand (rttt_pkg::ISQ_W'(t_r + prod_r)),
    .busy    (isq_busy),
    .root    (root)
  );

  rttt_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cor_start),
    .x     (x_r),
    .y     (y_r),
    .busy  (cor_busy),
    .angle (angle)
  );

  assign diff   = $signed({1'b0, r_r}) - $signed({1'b0, sel.rng});
  assign num    = 28'(diff) * 28'sd1000;
  assign mag_in = 26'(num < 0 ? -num : num) + 26'(dt_r >> 1);

  rttt_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mag_in),
    .divisor  (dt_r),
    .busy     (div_busy),
    .quotient (quo)
  );

  assign root_rnd = {1'b0, root} + 25'd128;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rttt_pkg::ST_IDLE: begin
        if (accept && in_ch.op == rttt_pkg::OP_DETECT) begin
          state_nxt = rttt_pkg::ST_SCAN;
        end
      end
      rttt_pkg::ST_SCAN: begin
        if (scan_r == IDX_W'(SLOTS - 1)) begin
          state_nxt = rttt_pkg::ST_PICK;
        end
      end
      rttt_pkg::ST_PICK:  state_nxt = hit ? rttt_pkg::ST_MUL0 : rttt_pkg::ST_DONE;
      rttt_pkg::ST_MUL0:  state_nxt = rttt_pkg::ST_MUL1;
      rttt_pkg::ST_MUL1:  state_nxt = rttt_pkg::ST_MUL2;
      rttt_pkg::ST_MUL2:  state_nxt = rttt_pkg::ST_MUL3;
      rttt_pkg::ST_MUL3:  state_nxt = rttt_pkg::ST_MUL4;
      rttt_pkg::ST_MUL4:  state_nxt = rttt_pkg::ST_MUL5;
      rttt_pkg::ST_MUL5:  state_nxt = rttt_pkg::ST_MUL6;
      rttt_pkg::ST_MUL6:  state_nxt = rttt_pkg::ST_ROOT;
      rttt_pkg::ST_ROOT: begin
        if (!isq_busy) begin
          state_nxt = rttt_pkg::ST_SPEED;
        end
      end
      rttt_pkg::ST_SPEED: begin
        state_nxt = (sel.rng != 16'd0) ? rttt_pkg::ST_DIV : rttt_pkg::ST_ANGLE;
      end
      rttt_pkg::ST_DIV: begin
        if (!div_busy) begin
          state_nxt = rttt_pkg::ST_ANGLE;
        end
      end
      rttt_pkg::ST_ANGLE: begin
        if (!cor_busy) begin
          state_nxt = rttt_pkg::ST_DONE;
        end
      end
      rttt_pkg::ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = rttt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rttt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = 1'b0;
    shift_en    = 1'b0;
    isq_start   = 1'b0;
    cor_start   = 1'b0;
    div_start   = 1'b0;
    load_out    = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    unique case (state_r)
      rttt_pkg::ST_IDLE:  in_ch.ready = 1'b1;
      rttt_pkg::ST_SCAN:  shift_en = 1'b1;
      rttt_pkg::ST_MUL0: begin
        mul_a = $signed({8'd0, g});
        mul_b = 25'(sx_r);
      end
      rttt_pkg::ST_MUL1: begin
        mul_a = $signed({8'd0, ig});
        mul_b = 25'(sel.xpos);
      end
      rttt_pkg::ST_MUL2: begin
        mul_a = $signed({8'd0, g});
        mul_b = 25'(sy_r);
      end
      rttt_pkg::ST_MUL3: begin
        mul_a = $signed({8'd0, ig});
        mul_b = 25'(sel.ypos);
      end
      rttt_pkg::ST_MUL4: begin
        mul_a = 25'(x_r);
        mul_b = 25'(x_r);
      end
      rttt_pkg::ST_MUL5: begin
        mul_a = 25'(y_r);
        mul_b = 25'(y_r);
      end
      rttt_pkg::ST_MUL6: begin
        isq_start = 1'b1;
        cor_start = 1'b1;
      end
      rttt_pkg::ST_SPEED: div_start = (sel.rng != 16'd0);
      rttt_pkg::ST_DONE:  load_out = !out_valid_r || out_ch.ready;
      default: ;
    endcase
  end

  always_comb begin
    ctl.shift = shift_en;
    ctl.tick  = 1'b0;
    ctl.clear = 1'b0;
    if (accept) begin
      unique case (in_ch.op)
        rttt_pkg::OP_FRAME: ctl.tick  = 1'b1;
        rttt_pkg::OP_CLEAR: ctl.clear = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rttt_pkg::ST_IDLE;
      gain_r      <= rttt_pkg::GAIN_RESET;
      expiry_r    <= rttt_pkg::EXPIRY_RESET;
      dt_r        <= rttt_pkg::DT_RESET;
      scan_r      <= '0;
      match_hit_r <= 1'b0;
      free_hit_r  <= 1'b0;
      tot_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          rttt_pkg::REG_GAIN:   gain_r   <= cfg_wdata;
          rttt_pkg::REG_EXPIRY: expiry_r <= cfg_wdata[7:0];
          default: ;
        endcase
      end
      if (accept && in_ch.op == rttt_pkg::OP_FRAME) begin
        dt_r <= (in_ch.frame_interval_ms == 16'd0) ? 16'd1 : in_ch.frame_interval_ms;
      end
      if (accept) begin
        scan_r      <= '0;
        match_hit_r <= 1'b0;
        free_hit_r  <= 1'b0;
        tot_r       <= '0;
      end else if (state_r == rttt_pkg::ST_SCAN) begin
        scan_r <= scan_r + IDX_W'(1);
        if (!match_hit_r && head.valid && head.ident == id_r) begin
          match_hit_r <= 1'b1;
        end
        if (!free_hit_r && (!head.valid || head.lost > expiry_r)) begin
          free_hit_r <= 1'b1;
        end
        if (head.valid && head.lost == 8'd0) begin
          tot_r <= tot_r + CNT_W'(1);
        end
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (accept) begin
      id_r <= in_ch.target_id;
      sx_r <= in_ch.x_mm;
      sy_r <= in_ch.y_mm;
    end
    if (state_r == rttt_pkg::ST_SCAN) begin
      if (!match_hit_r && head.valid && head.ident == id_r) begin
        match_s_r   <= head;
        match_idx_r <= scan_r;
      end
      if (!free_hit_r && (!head.valid || head.lost > expiry_r)) begin
        free_s_r   <= head;
        free_idx_r <= scan_r;
      end
    end
    case (state_r)
      rttt_pkg::ST_MUL1, rttt_pkg::ST_MUL3, rttt_pkg::ST_MUL5: t_r <= prod_r;
      rttt_pkg::ST_MUL2: x_r <= blend(t_r, prod_r);
      rttt_pkg::ST_MUL4: y_r <= blend(t_r, prod_r);
      rttt_pkg::ST_ROOT: r_r <= root_rnd[23:8];
      rttt_pkg::ST_SPEED: begin
        neg_r <= num < 0;
        spd_r <= '0;
      end
      rttt_pkg::ST_DIV: begin
        if (neg_r) begin
          spd_r <= (quo > 26'd8388608) ? -24'sd8388608 : -$signed(24'(quo));
        end else begin
          spd_r <= (quo > 26'd8388607) ? 24'sd8388607 : $signed(24'(quo));
        end
      end
      default: ;
    endcase
    if (load_out) begin
      out_found_r <= hit;
      out_idx_r   <= hit ? 4'(sel_idx) : 4'd0;
      out_id_r    <= hit ? id_r : 8'd0;
      out_x_r     <= hit ? x_r : 24'sd0;
      out_y_r     <= hit ? y_r : 24'sd0;
      out_rng_r   <= hit ? r_r : 16'd0;
      out_brg_r   <= hit ? angle : 16'sd0;
      out_spd_r   <= hit ? spd_r : 24'sd0;
      out_act_r   <= 5'(cnt_fin);
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.slot_found       = out_found_r;
  assign out_ch.slot_index       = out_idx_r;
  assign out_ch.track_id         = out_id_r;
  assign out_ch.smooth_x         = out_x_r;
  assign out_ch.smooth_y         = out_y_r;
  assign out_ch.range_mm         = out_rng_r;
  assign out_ch.bearing_centideg = out_brg_r;
  assign out_ch.radial_speed     = out_spd_r;
  assign out_ch.active_count     = out_act_r;

  // A result only ever appears from the hand-over state.
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(state_r == rttt_pkg::ST_DONE))
    else $error("result appeared outside the hand-over state");

  // The ring must be back in place before any slot is written.
  a_write_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (|wr_en) |-> $past(state_r != rttt_pkg::ST_SCAN))
    else $error("slot written while the ring was rotating");

  // At most one cell takes the write-back.
  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(wr_en))
    else $error("more than one slot written");

  // The active count can never exceed the table size.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> (cnt_fin <= CNT_W'(SLOTS)))
    else $error("active count beyond the table size");

endmodule

/* tb/rttt_tb_checker.sv */
`timescale 1ns / 1ps

module rttt_tb_checker (
  input  logic        clk,
  input  logic        rst_n,
  rttt_in_if          in_ch,
  rttt_out_if         out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_wdata,
  output int          fail_count,
  output int          pending,
  output int          results_seen
);

  typedef struct packed {
    logic               found;
    logic [3:0]         index;
    logic [7:0]         id;
    logic signed [23:0] sx;
    logic signed [23:0] sy;
    logic [15:0]        rng;
    logic signed [15:0] brg;
    logic signed [23:0] spd;
    logic [4:0]         active;
  } track_report_t;

  track_report_t reports_due[$];

  logic [16:0]     gain_q;
  logic [7:0]      expiry_q;
  logic [15:0]     dt_q;
  rttt_pkg::slot_t table_q [rttt_pkg::SLOTS_DEF];

  assign pending = reports_due.size();

  function automatic longint floor_div_pow2(longint v, int s);
    longint d;
    d = longint'(1) << s;
    if (v >= 0) return v / d;
    return -(((-v) + d - 1) / d);
  endfunction

  function automatic longint int_root(longint n);
    longint res, bit_v;
    res = 0;
    bit_v = longint'(1) << 62;
    while (bit_v > n) bit_v = bit_v >>> 2;
    while (bit_v != 0) begin
      if (n >= res + bit_v) begin
        n = n - (res + bit_v);
        res = (res >>> 1) + bit_v;
      end else begin
        res = res >>> 1;
      end
      bit_v = bit_v >>> 2;
    end
    return res;
  endfunction

  function automatic longint ema_blend(longint prev, longint sample, longint g);
    longint v;
    v = floor_div_pow2(g * (sample * 256) + (65536 - g) * prev + 32768, 16);
    if (v < -8388608) v = -8388608;
    if (v > 8388607) v = 8388607;
    return v;
  endfunction

  function automatic longint atan_step(int i);
    case (i)
      0: return 1152000;  1: return 680065;  2: return 359328;  3: return 182400;
      4: return 91554;    5: return 45822;   6: return 22916;   7: return 11459;
      8: return 5730;     9: return 2865;    10: return 1432;   11: return 716;
      12: return 358;     13: return 179;    14: return 90;
      default: return 45;
    endcase
  endfunction

  function automatic longint bearing_of(longint x, longint y);
    longint u, v, z, t, du, dv;
    if (x == 0 && y == 0) return 0;
    u = y * 64;
    v = x * 64;
    z = 0;
    if (u < 0) begin
      if (v >= 0) begin
        t = u; u = v; v = -t; z = 2304000;
      end else begin
        t = u; u = -v; v = t; z = -2304000;
      end
    end
    for (int i = 0; i < 16; i++) begin
      du = floor_div_pow2(v, i);
      dv = floor_div_pow2(u, i);
      if (v >= 0) begin
        u += du; v -= dv; z += atan_step(i);
      end else begin
        u -= du; v += dv; z -= atan_step(i);
      end
    end
    z = floor_div_pow2(z + 128, 8);
    if (z < -18000) z = -18000;
    if (z > 18000) z = 18000;
    return z;
  endfunction

  task automatic track_request(input logic [1:0] op, input logic [7:0] id,
                               input logic signed [15:0] xs, input logic signed [15:0] ys,
                               input logic [15:0] dt);
    int slot, active;
    longint g, xp, yp, r, r_old, num, mag, d, spd;
    track_report_t rep;
    slot = -1;
    active = 0;
    rep = '0;
    case (op)
      rttt_pkg::OP_FRAME: begin
        foreach (table_q[i])
          if (table_q[i].lost != rttt_pkg::LOST_MAX) table_q[i].lost++;
        dt_q = (dt == 0) ? 16'd1 : dt;
      end
      rttt_pkg::OP_CLEAR: foreach (table_q[i]) table_q[i] = rttt_pkg::SLOT_RESET;
      rttt_pkg::OP_DETECT: begin
        for (int i = 0; i < rttt_pkg::SLOTS_DEF && slot < 0; i++)
          if (table_q[i].valid && table_q[i].ident == id) slot = i;
        for (int i = 0; i < rttt_pkg::SLOTS_DEF && slot < 0; i++)
          if (!table_q[i].valid || table_q[i].lost > expiry_q) slot = i;
        if (slot >= 0) begin
          g = (gain_q > rttt_pkg::GAIN_ONE) ? 65536 : longint'(gain_q);
          r_old = table_q[slot].rng;
          xp = ema_blend(table_q[slot].xpos, xs, g);
          yp = ema_blend(table_q[slot].ypos, ys, g);
          r = (int_root(xp * xp + yp * yp) + 128) >>> 8;
          table_q[slot].ident = id;
          table_q[slot].xpos = xp;
          table_q[slot].ypos = yp;
          table_q[slot].rng = r;
          table_q[slot].lost = 0;
          table_q[slot].valid = 1'b1;
          spd = 0;
          if (r_old > 0) begin
            num = (r - r_old) * 1000;
            d = dt_q;
            mag = ((num < 0 ? -num : num) + d / 2) / d;
            spd = num < 0 ? -mag : mag;
            if (spd < -8388608) spd = -8388608;
            if (spd > 8388607) spd = 8388607;
          end
          rep.found = 1'b1;
          rep.index = slot;
          rep.id = id;
          rep.sx = xp;
          rep.sy = yp;
          rep.rng = r;
          rep.brg = bearing_of(xp, yp);
          rep.spd = spd;
        end
        foreach (table_q[i]) if (table_q[i].valid && table_q[i].lost == 0) active++;
        rep.active = active;
        reports_due.push_back(rep);
      end
      default: ;
    endcase
  endtask

  task automatic compare_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    track_report_t want;
    if (!rst_n) begin
      gain_q <= rttt_pkg::GAIN_RESET;
      expiry_q <= rttt_pkg::EXPIRY_RESET;
      dt_q <= rttt_pkg::DT_RESET;
      foreach (table_q[i]) table_q[i] <= rttt_pkg::SLOT_RESET;
      reports_due.delete();
      fail_count <= 0;
      results_seen <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == rttt_pkg::REG_GAIN) gain_q = cfg_wdata;
        else if (cfg_index == rttt_pkg::REG_EXPIRY) expiry_q = cfg_wdata[7:0];
      end
      if (out_ch.valid && out_ch.ready) begin
        results_seen <= results_seen + 1;
        if (reports_due.size() == 0) begin
          $error("unexpected track report");
          fail_count++;
        end else begin
          want = reports_due.pop_front();
          compare_field("slot_found", want.found, out_ch.slot_found);
          compare_field("slot_index", want.index, out_ch.slot_index);
          compare_field("track_id", want.id, out_ch.track_id);
          compare_field("smooth_x", want.sx, out_ch.smooth_x);
          compare_field("smooth_y", want.sy, out_ch.smooth_y);
          compare_field("range_mm", want.rng, out_ch.range_mm);
          compare_field("bearing_centideg", want.brg, out_ch.bearing_centideg);
          compare_field("radial_speed", want.spd, out_ch.radial_speed);
          compare_field("active_count", want.active, out_ch.active_count);
        end
      end
      if (in_ch.valid && in_ch.ready)
        track_request(in_ch.op, in_ch.target_id, in_ch.x_mm, in_ch.y_mm,
                      in_ch.frame_interval_ms);
    end
  end
endmodule

/* tb/tb_radar_target_track_table_core.sv */
`timescale 1ns / 1ps

module tb_radar_target_track_table_core;

  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [16:0] cfg_wdata;
  int          fail_count;
  int          pending;
  int          results_seen;
  int          sender_idle_pct;
  int          receiver_stall_pct;
  int          requests_sent;
  int          quiet_cycles;

  rttt_in_if  in_ch ();
  rttt_out_if out_ch ();

  radar_target_track_table_core dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  rttt_tb_checker checker_i (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending), .results_seen(results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver stalls at random, driven at the falling edge.
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // The request stays asserted after acceptance until the next one or an idle cycle.
  task automatic send_request(input logic [1:0] op, input logic [7:0] id,
                              input logic [15:0] x, input logic [15:0] y,
                              input logic [15:0] dt);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.target_id <= id;
    in_ch.x_mm <= x;
    in_ch.y_mm <= y;
    in_ch.frame_interval_ms <= dt;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    requests_sent++;
  endtask

  task automatic drain_table;
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (120) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [16:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(3))
      0: return 16'($signed($urandom_range(4000)) - 2000);
      1: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_phase(input int count);
    logic [1:0] op;
    int pick;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 12) op = rttt_pkg::OP_FRAME;
      else if (pick < 14) op = rttt_pkg::OP_CLEAR;
      else if (pick < 16) op = rttt_pkg::OP_NONE;
      else op = rttt_pkg::OP_DETECT;
      send_request(op, $urandom_range(99) < 80 ? 8'($urandom_range(23)) : 8'($urandom),
                   rand_coord(), rand_coord(),
                   $urandom_range(9) == 0 ? 16'($urandom) : 16'($urandom_range(200)));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = rttt_pkg::REG_GAIN;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.op = rttt_pkg::OP_FRAME;
    in_ch.target_id = '0;
    in_ch.x_mm = '0;
    in_ch.y_mm = '0;
    in_ch.frame_interval_ms = '0;
    out_ch.ready = 1'b0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    requests_sent = 0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // Directed: extremes of position, id and interval, every op, full table.
    send_request(rttt_pkg::OP_DETECT, 8'd0, 16'h0000, 16'h0000, 16'd0);
    send_request(rttt_pkg::OP_DETECT, 8'd255, 16'h7FFF, 16'h7FFF, 16'hFFFF);
    send_request(rttt_pkg::OP_DETECT, 8'd255, 16'h8000, 16'h8000, 16'd0);
    send_request(rttt_pkg::OP_DETECT, 8'd7, 16'h8000, 16'h0001, 16'd0);
    send_request(rttt_pkg::OP_FRAME, 8'd0, 16'h0, 16'h0, 16'd0);
    send_request(rttt_pkg::OP_DETECT, 8'd7, 16'h7FFF, 16'hFFFF, 16'd0);
    send_request(rttt_pkg::OP_FRAME, 8'd0, 16'h0, 16'h0, 16'hFFFF);
    send_request(rttt_pkg::OP_DETECT, 8'd255, 16'h1234, 16'h8000, 16'd0);
    send_request(rttt_pkg::OP_NONE, 8'hAA, 16'h5555, 16'hAAAA, 16'h5555);
    for (int i = 0; i < 14; i++)
      send_request(rttt_pkg::OP_DETECT, 8'(100 + i), 16'(i * 300), 16'(-i * 500), 16'd0);
    send_request(rttt_pkg::OP_DETECT, 8'd99, 16'h0100, 16'h0100, 16'd0);
    send_request(rttt_pkg::OP_CLEAR, 8'd0, 16'h0, 16'h0, 16'd0);
    drain_table();

    // Gain above one and zero gain, then the expiry extremes.
    write_reg(rttt_pkg::REG_GAIN, 17'h1FFFF);
    write_reg(rttt_pkg::REG_EXPIRY, 17'd0);
    write_reg(rttt_pkg::REG_NONE, 17'd1);
    random_phase(200);
    drain_table();

    write_reg(rttt_pkg::REG_GAIN, 17'd0);
    write_reg(rttt_pkg::REG_EXPIRY, 17'd254);
    sender_idle_pct = 79;
    random_phase(150);
    drain_table();

    write_reg(rttt_pkg::REG_GAIN, rttt_pkg::GAIN_ONE);
    write_reg(rttt_pkg::REG_EXPIRY, 17'd2);
    sender_idle_pct = 0;
    receiver_stall_pct = 79;
    random_phase(200);
    drain_table();

    write_reg(rttt_pkg::REG_GAIN, 17'($urandom_range(65536)));
    write_reg(rttt_pkg::REG_EXPIRY, 17'($urandom_range(20)));
    sender_idle_pct = 30;
    receiver_stall_pct = 30;
    random_phase(250);
    drain_table();

    write_reg(rttt_pkg::REG_GAIN, rttt_pkg::GAIN_RESET);
    write_reg(rttt_pkg::REG_EXPIRY, 17'(rttt_pkg::EXPIRY_RESET));
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    random_phase(325);
    drain_table();

    $display("Covered %0d requests and %0d track reports over five gain/expiry settings",
             requests_sent, results_seen);
    $display("with sender gaps and receiver stalls in turn.");
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
